[sv/half_step_stepper_sequencer_defines.svh]
`ifndef HALF_STEP_STEPPER_SEQUENCER_DEFINES_SVH
`define HALF_STEP_STEPPER_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define HSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hss assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define HSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hss assertion failed");

`endif

[sv/hss_pkg.sv]
package hss_pkg;

    localparam int DEF_STEP_COUNT_WIDTH = 22;

    localparam int OPCODE_W    = 2;
    localparam int MOVE_W      = 21;
    localparam int COIL_W      = 4;
    localparam int STEPS_W     = 22;
    localparam int POS_W       = 3;
    localparam int SPEED_W     = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int INTERVAL_W  = 10;

    localparam int SPEED_CAP     = 1100;
    localparam int TICK_RATE     = 100000;
    localparam int SLOW_LIMIT    = 650;
    localparam int SLOW_INTERVAL = 1000;

    localparam int DIVIDEND_W = 17;
    localparam int DIVISOR_W  = SPEED_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_STOP = 2'd2
    } t_opcode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STEP_SPEED        = 2'd0,
        REG_REVERSE_DIRECTION = 2'd1
    } t_reg_index;

    function automatic logic [COIL_W-1:0] coil_code(input logic [POS_W-1:0] pos);
        logic [COIL_W-1:0] code;
        case (pos)
            3'd0: code = 4'd5;
            3'd1: code = 4'd4;
            3'd2: code = 4'd6;
            3'd3: code = 4'd2;
            3'd4: code = 4'd10;
            3'd5: code = 4'd8;
            3'd6: code = 4'd9;
            3'd7: code = 4'd1;
            default: code = 4'd0;
        endcase
        return code;
    endfunction

endpackage

[sv/hss_cmd_if.sv]
interface hss_cmd_if;
    import hss_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [MOVE_W-1:0]   move_steps;

    modport source (output valid, output opcode, output move_steps, input ready);
    modport sink   (input valid, input opcode, input move_steps, output ready);
endinterface

[sv/hss_res_if.sv]
interface hss_res_if;
    import hss_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [COIL_W-1:0]          coil_pattern;
    logic signed [STEPS_W-1:0]  steps_remaining;
    logic                       stepped;

    modport source (output valid, output coil_pattern, output steps_remaining,
                    output stepped, input ready);
    modport sink   (input valid, input coil_pattern, input steps_remaining,
                    input stepped, output ready);
endinterface

[sv/hss_cfg_if.sv]
interface hss_cfg_if;
    import hss_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/half_step_stepper_sequencer.sv]
// Half-step sequencer for one four-coil stepper motor. Each command transfer yields exactly one
// result transfer. Move and stop commands, unused opcodes and ticks at a doubled speed below 650
// pass from accept through S_STEP into the output register; a tick at a higher speed first waits
// in S_DIV for the restoring division of the 17-bit dividend 100000 by the doubled speed. The
// command channel is not ready while an item is in work; a finished result sits in an output
// register, so the next command is accepted while it waits, and a further result waits for it to
// drain. Configuration writes are always taken and belong in idle periods only.
`include "half_step_stepper_sequencer_defines.svh"

module half_step_stepper_sequencer #(
    parameter int STEP_COUNT_WIDTH = hss_pkg::DEF_STEP_COUNT_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hss_cmd_if.sink     i_cmd,
    hss_res_if.source   o_res,
    hss_cfg_if.sink     i_cfg
);
    import hss_pkg::*;

    localparam int W  = STEP_COUNT_WIDTH;
    localparam int EW = (W > STEPS_W) ? W : STEPS_W;
    localparam logic signed [EW-1:0] CNT_HI = {{(EW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [EW-1:0] CNT_LO = ~CNT_HI;
    localparam logic [INTERVAL_W-1:0] TICK_LIMIT = INTERVAL_W'(SLOW_INTERVAL);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_STEP = 3'b100
    } t_state;

    t_state                    r_state;
    logic [SPEED_W-1:0]        r_speed;
    logic                      r_rev;
    logic [OPCODE_W-1:0]       r_op;
    logic signed [MOVE_W-1:0]  r_move;
    logic [INTERVAL_W-1:0]     r_interval;
    logic [POS_W-1:0]          r_pos;
    logic signed [W-1:0]       r_cnt;
    logic [INTERVAL_W-1:0]     r_tick;
    logic [COIL_W-1:0]         r_coil;
    logic                      r_out_valid;
    logic [COIL_W-1:0]         r_out_coil;
    logic signed [STEPS_W-1:0] r_out_steps;
    logic                      r_out_stepped;

    logic [POS_W-1:0]          n_pos;
    logic signed [W-1:0]       n_cnt;
    logic [INTERVAL_W-1:0]     n_tick;
    logic [COIL_W-1:0]         n_coil;

    logic                      accept;
    logic [SPEED_W-2:0]        spd_cap;
    logic [SPEED_W-1:0]        spd_dbl;
    logic                      slow;
    logic                      div_start;
    logic                      div_done;
    logic [DIVIDEND_W-1:0]     div_quo;
    logic                      out_free;
    logic                      res_load;
    logic [INTERVAL_W:0]       next_tick;
    logic                      fire;
    logic                      cnt_zero;
    logic                      cnt_pos;
    logic                      up;
    logic signed [STEPS_W-1:0] mv_dbl;
    logic signed [EW-1:0]      mv_ext;
    logic signed [EW-1:0]      cnt_ext;

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;

    // interval select: saturate, double, slow speeds use the fixed interval
    assign spd_cap   = (r_speed > SPEED_W'(SPEED_CAP)) ? (SPEED_W-1)'(SPEED_CAP)
                                                      : r_speed[SPEED_W-2:0];
    assign spd_dbl   = {spd_cap, 1'b0};
    assign slow      = (spd_dbl < SPEED_W'(SLOW_LIMIT));
    assign div_start = accept && (i_cmd.opcode == OP_TICK) && !slow;

    hss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (spd_dbl),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign out_free = !r_out_valid || o_res.ready;
    assign res_load = (r_state == S_STEP) && out_free;

    assign next_tick = {1'b0, r_tick} + 1'b1;
    assign fire      = (r_op == OP_TICK) && (next_tick >= {1'b0, r_interval});
    assign cnt_zero  = (r_cnt == '0);
    assign cnt_pos   = !r_cnt[W-1] && !cnt_zero;
    assign up        = cnt_pos != r_rev;

    assign mv_dbl  = {r_move, 1'b0};
    assign mv_ext  = EW'(mv_dbl);
    assign cnt_ext = EW'(n_cnt);

    always_comb begin
        n_pos  = r_pos;
        n_cnt  = r_cnt;
        n_tick = r_tick;
        n_coil = r_coil;
        case (r_op)
            OP_TICK: begin
                if (fire) begin
                    n_tick = '0;
                    if (cnt_zero) begin
                        n_coil = '0;
                    end else begin
                        n_pos  = up ? r_pos + 1'b1 : r_pos - 1'b1;
                        n_coil = coil_code(n_pos);
                        n_cnt  = cnt_pos ? r_cnt - 1'b1 : r_cnt + 1'b1;
                    end
                end else begin
                    n_tick = next_tick[INTERVAL_W-1:0];
                end
            end
            OP_MOVE: begin
                if (mv_ext > CNT_HI) begin
                    n_cnt = CNT_HI[W-1:0];
                end else if (mv_ext < CNT_LO) begin
                    n_cnt = CNT_LO[W-1:0];
                end else begin
                    n_cnt = mv_ext[W-1:0];
                end
            end
            OP_STOP: begin
                n_cnt = '0;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_rev   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_STEP_SPEED:        r_speed <= i_cfg.data[SPEED_W-1:0];
                REG_REVERSE_DIRECTION: r_rev   <= i_cfg.data[0];
                default:               r_rev   <= r_rev;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_tick      <= '0;
            r_coil      <= '0;
        end else begin
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= div_start ? S_DIV : S_STEP;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (out_free) begin
                        r_state     <= S_IDLE;
                        r_pos       <= n_pos;
                        r_cnt       <= n_cnt;
                        r_tick      <= n_tick;
                        r_coil      <= n_coil;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_cmd.opcode;
            r_move     <= i_cmd.move_steps;
            r_interval <= TICK_LIMIT;
        end else if ((r_state == S_DIV) && div_done) begin
            r_interval <= div_quo[INTERVAL_W-1:0];
        end
        if (res_load) begin
            r_out_coil    <= n_coil;
            r_out_steps   <= cnt_ext[STEPS_W-1:0];
            r_out_stepped <= fire;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.coil_pattern    = r_out_coil;
    assign o_res.steps_remaining = r_out_steps;
    assign o_res.stepped         = r_out_stepped;

    `HSS_ASSERT_NOW(a_tick_below_limit, 1'b1, r_tick < TICK_LIMIT)
    `HSS_ASSERT_NOW(a_div_done_in_div, div_done, r_state == S_DIV)
    `HSS_ASSERT_NEXT(a_fire_clears_tick, res_load && fire, r_tick == '0)
    `HSS_ASSERT_NEXT(a_empty_count_coils_off, res_load && fire && cnt_zero, r_coil == '0)

endmodule

[sv/hss_div.sv]
module hss_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [hss_pkg::DIVISOR_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [hss_pkg::DIVIDEND_W-1:0] o_quotient
);
    import hss_pkg::*;

    localparam logic [DIVIDEND_W-1:0] DIVIDEND = DIVIDEND_W'(TICK_RATE);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  ge;
    logic [DIVISOR_W-1:0]  n_rem;

    // one restoring step per cycle, quotient shifts in behind the dividend
    assign rem_sh   = {r_rem, r_quo[DIVIDEND_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_div};
    assign ge       = (rem_sh >= {1'b0, r_div});
    assign n_rem    = ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= DIVIDEND;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[verif/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hss_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_IDLE        = 16;
    localparam int STEP_COUNT_BITS = DEF_STEP_COUNT_WIDTH;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [COIL_W-1:0] HALF_STEP_COILS [8] =
        '{4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9, 4'h1};

    typedef struct {
        logic [COIL_W-1:0]         coils;
        logic signed [STEPS_W-1:0] left;
        logic                      fired;
    } t_drive_state;

    logic i_clk;
    logic i_rst_n;

    hss_cmd_if cmd_if ();
    hss_res_if res_if ();
    hss_cfg_if cfg_if ();

    half_step_stepper_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // motor model state
    logic [SPEED_W-1:0] speed_reg;
    logic               rev_reg;
    logic [POS_W-1:0]   table_pos;
    longint             half_steps;
    int unsigned        tick_count;
    logic [COIL_W-1:0]  coils;

    t_drive_state predicted_drive_q[$];

    bit tx_idle;
    bit rx_idle;
    int hold_request;
    int n_errors;
    int n_items;
    int n_checked;
    int n_fired;
    int n_writes;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(20_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned step_interval();
        int unsigned s;
        s = (speed_reg > SPEED_CAP) ? SPEED_CAP : speed_reg;
        s = s * 2;
        return (s < SLOW_LIMIT) ? SLOW_INTERVAL : TICK_RATE / s;
    endfunction

    function automatic longint load_half_steps(input logic signed [MOVE_W-1:0] steps);
        longint hi;
        longint lo;
        longint v;
        hi = (longint'(1) <<< (STEP_COUNT_BITS - 1)) - 1;
        lo = -hi - 1;
        v  = longint'(steps) * 2;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v;
    endfunction

    function automatic logic signed [MOVE_W-1:0] random_move_steps();
        logic signed [MOVE_W-1:0] v;
        if ($urandom_range(0, 3) == 0) begin
            v = MOVE_W'($urandom);
        end else begin
            v = MOVE_W'($urandom_range(0, 40));
            if ($urandom_range(0, 1) == 1) v = -v;
        end
        return v;
    endfunction

    task automatic advance_motor(input logic [OPCODE_W-1:0] op,
                                 input logic signed [MOVE_W-1:0] steps);
        int unsigned  interval;
        logic         up;
        t_drive_state r;
        r.fired = 1'b0;
        if (op == OP_TICK) begin
            interval = step_interval();
            if (tick_count + 1 >= interval) begin
                tick_count = 0;
                r.fired    = 1'b1;
                if (half_steps != 0) begin
                    up        = (half_steps > 0) != rev_reg;
                    table_pos = up ? table_pos + 3'd1 : table_pos - 3'd1;
                    coils     = HALF_STEP_COILS[table_pos];
                    half_steps = (half_steps > 0) ? half_steps - 1 : half_steps + 1;
                end else begin
                    coils = '0;
                end
            end else begin
                tick_count = tick_count + 1;
            end
        end else if (op == OP_MOVE) begin
            half_steps = load_half_steps(steps);
        end else if (op == OP_STOP) begin
            half_steps = 0;
        end
        r.coils = coils;
        r.left  = STEPS_W'(half_steps);
        predicted_drive_q.push_back(r);
    endtask

    task automatic send_item(input logic [OPCODE_W-1:0] op,
                             input logic signed [MOVE_W-1:0] steps);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.opcode     <= op;
        cmd_if.move_steps <= steps;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        advance_motor(op, steps);
        n_items++;
    endtask

    task automatic send_random_item(input int tick_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < tick_pct) begin
            send_item(OP_TICK, random_move_steps());
        end else begin
            r = $urandom_range(0, 9);
            if (r < 7) send_item(OP_MOVE, random_move_steps());
            else if (r < 9) send_item(OP_STOP, random_move_steps());
            else send_item(OP_UNUSED, random_move_steps());
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (predicted_drive_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        if (idx == REG_STEP_SPEED) speed_reg = value;
        else if (idx == REG_REVERSE_DIRECTION) rev_reg = value[0];
        n_writes++;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_direction(input logic rev);
        logic [CFG_DATA_W-1:0] value;
        // upper bits carry noise, only bit 0 counts
        value    = CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1);
        value[0] = rev;
        write_reg(REG_REVERSE_DIRECTION, value);
    endtask

    task automatic run_phase(input logic [SPEED_W-1:0] speed, input logic rev,
                             input int n, input bit tx_gaps, input bit rx_gaps);
        write_reg(REG_STEP_SPEED, speed);
        write_direction(rev);
        tx_idle = tx_gaps;
        rx_idle = rx_gaps;
        repeat (n) send_random_item(93);
    endtask

    task automatic test_opcode_extremes();
        send_item(OP_TICK, '0);
        send_item(OP_UNUSED, 21'sh0FFFFF);
        send_item(OP_MOVE, 21'sh0FFFFF);
        send_item(OP_UNUSED, '0);
        send_item(OP_TICK, 21'sh100000);
        send_item(OP_MOVE, 21'sh100000);
        send_item(OP_TICK, '1);
        send_item(OP_MOVE, '0);
        send_item(OP_MOVE, 21'sd1);
        send_item(OP_MOVE, -21'sd1);
        send_item(OP_STOP, 21'sh0FFFFF);
        send_item(OP_UNUSED, 21'sh100000);
    endtask

    task automatic test_speed_boundaries();
        logic [SPEED_W-1:0] speeds [5] = '{12'd0, 12'd324, 12'd325, 12'd1100, 12'd4095};
        foreach (speeds[i]) begin
            write_reg(REG_STEP_SPEED, speeds[i]);
            if (i == 2) write_direction(1'b1);
            send_item(OP_MOVE, random_move_steps());
            send_item(OP_TICK, '0);
        end
        write_direction(1'b0);
    endtask

    task automatic test_fast_phases();
        run_phase(12'd4095, 1'b0, 120, 1'b1, 1'b1);
        run_phase(12'd325, 1'b1, 120, 1'b0, 1'b0);
        run_phase(12'd1100, 1'b1, 120, 1'b1, 1'b0);
    endtask

    // at least one full slow interval, so the counter runs well past any fast interval
    task automatic test_slow_interval();
        int ticks;
        write_reg(REG_STEP_SPEED, SPEED_W'($urandom_range(0, 324)));
        write_direction(1'b0);
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        send_item(OP_MOVE, MOVE_W'($urandom_range(1, 8)));
        ticks = 0;
        while (ticks < 1060) begin
            if ($urandom_range(0, 99) < 98) begin
                send_item(OP_TICK, random_move_steps());
                ticks++;
            end else begin
                send_random_item(0);
            end
        end
    endtask

    task automatic test_interval_shrink();
        run_phase(12'd4095, 1'b0, 120, 1'b0, 1'b1);
        run_phase(SPEED_W'($urandom_range(325, 4095)), 1'($urandom), 60, 1'b1, 1'b1);
    endtask

    task automatic test_output_stall();
        wait_idle();
        tx_idle      = 1'b0;
        rx_idle      = 1'b1;
        hold_request = 400;
        repeat (12) send_random_item(80);
    endtask

    task automatic test_input_pause();
        tx_idle = 1'b1;
        repeat (3) begin
            repeat (8) send_random_item(85);
            wait_idle();
        end
    endtask

    // result side: random stalls, one long hold on request
    initial begin
        int           stall;
        t_drive_state exp;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end
            @(negedge i_clk);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            if (predicted_drive_q.size() == 0) begin
                $error("result transfer with nothing expected");
                n_errors++;
            end else begin
                exp = predicted_drive_q.pop_front();
                n_checked++;
                if (exp.fired) n_fired++;
                if (res_if.coil_pattern !== exp.coils) begin
                    $error("coil_pattern: expected %0h, actual %0h",
                           exp.coils, res_if.coil_pattern);
                    n_errors++;
                end
                if (res_if.steps_remaining !== exp.left) begin
                    $error("steps_remaining: expected %0d, actual %0d",
                           exp.left, res_if.steps_remaining);
                    n_errors++;
                end
                if (res_if.stepped !== exp.fired) begin
                    $error("stepped: expected %0b, actual %0b", exp.fired, res_if.stepped);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.opcode     = '0;
        cmd_if.move_steps = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
        speed_reg         = '0;
        rev_reg           = 1'b0;
        table_pos         = '0;
        half_steps        = 0;
        tick_count        = 0;
        coils             = '0;
        tx_idle           = 1'b1;
        rx_idle           = 1'b1;
        hold_request      = 0;
        n_errors          = 0;
        n_items           = 0;
        n_checked         = 0;
        n_fired           = 0;
        n_writes          = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_opcode_extremes();
        test_speed_boundaries();
        test_fast_phases();
        test_slow_interval();
        test_interval_shrink();
        test_output_stall();
        test_input_pause();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d command transfers and %0d result checks, %0d of them steps,",
                 n_items, n_checked, n_fired);
        $display("over %0d register writes from slowest to saturated speed, both directions",
                 n_writes);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
